// ===== rtl/core/crt_pkg.sv =====
// Shared constants, codes and types of the chunk coverage tracker.
`timescale 1ns / 1ps
`default_nettype none
package crt_pkg;
	localparam int SIZE_BITS     = 16;
	localparam int MAX_INTERVALS = 16;
	localparam int POS_W         = SIZE_BITS + 1;
	localparam int IDX_W         = $clog2(MAX_INTERVALS);
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 2);
	localparam int ADDR_W        = IDX_W + 1;
	localparam int COUNT_OUT_W   = 5;
	localparam int REG_ADDR_W    = 3;

	localparam logic [POS_W-1:0] SIZE_CAP = POS_W'(1) << SIZE_BITS;

	// word index of the object size register
	localparam logic REG_OBJECT_SIZE = 1'b0;

	typedef enum logic [1:0] {
		STAT_PARTIAL    = 2'd0,
		STAT_COMPLETE   = 2'd1,
		STAT_BAD_RANGE  = 2'd2,
		STAT_TABLE_FULL = 2'd3
	} status_t;

	typedef struct packed {
		status_t                  status;
		logic                     copy_needed;
		logic [COUNT_OUT_W-1:0]   interval_count;
	} crt_result_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic out_free;
	} crt_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/core/crt_merge_engine.sv =====
// Interval table and merge sequencer: streams the old table into the spare bank.
`timescale 1ns / 1ps
`default_nettype none
module crt_merge_engine
	import crt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  crt_ctrl_t            ctrl,
	input  logic [SIZE_BITS-1:0] chunk_start,
	input  logic [POS_W-1:0]     chunk_end,
	input  logic [POS_W-1:0]     object_size,
	output logic                 ready,
	output logic                 done,
	output crt_result_t          result
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_FLUSH  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERVALS);

	state_t state_q;

	// two banks of MAX_INTERVALS entries; sel_q picks the live one
	logic [2*POS_W-1:0] mem [2*MAX_INTERVALS];
	logic [2*POS_W-1:0] rd_q;
	logic               sel_q;

	logic [POS_W-1:0] s_q, e_q;
	logic [CNT_W-1:0] count_q, i_q, j_q;
	logic             pend_q, acc_v_q, contained_q, first_full_q;
	logic [POS_W-1:0] acc_s_q, acc_e_q;
	crt_result_t      res_q;

	logic [POS_W-1:0]  rd_a, rd_b, item_s, item_e;
	logic              have_old, take_chunk, merge, scan_end, flush_en, wr_en;
	logic              bad, first_now, ff, over, complete;
	logic [CNT_W-1:0]  i_d, new_j;
	logic [ADDR_W-1:0] rd_addr, wr_addr;

	assign rd_a = rd_q[2*POS_W-1:POS_W];
	assign rd_b = rd_q[POS_W-1:0];

	always_comb begin
		have_old   = i_q < count_q;
		take_chunk = pend_q && (!have_old || s_q <= rd_a);
		item_s     = take_chunk ? s_q : rd_a;
		item_e     = take_chunk ? e_q : rd_b;
		merge      = acc_v_q && (item_s <= acc_e_q);
		scan_end   = !have_old && !pend_q;
		flush_en   = ((state_q == ST_SCAN) && !scan_end && !merge && acc_v_q) ||
		             (state_q == ST_FLUSH);
		wr_en      = flush_en && (j_q < MAX_CNT);
		bad        = (s_q >= e_q) || (e_q > object_size);
		first_now  = (acc_s_q == '0) && (acc_e_q == object_size);
		ff         = (j_q == '0) ? first_now : first_full_q;
		new_j      = j_q + CNT_W'(1);
		over       = new_j > MAX_CNT;
		complete   = !over && (new_j == CNT_W'(1)) && ff;
		case (state_q)
			ST_SCAN: begin
				i_d = (!scan_end && !take_chunk) ? i_q + CNT_W'(1) : i_q;
			end
			ST_FLUSH, ST_RESULT: begin
				i_d = i_q;
			end
			default: begin
				i_d = '0;
			end
		endcase
		rd_addr = {sel_q, i_d[IDX_W-1:0]};
		wr_addr = {~sel_q, j_q[IDX_W-1:0]};
	end

	// table storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {acc_s_q, acc_e_q};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sel_q        <= 1'b0;
			count_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			pend_q       <= 1'b0;
			acc_v_q      <= 1'b0;
			contained_q  <= 1'b0;
			first_full_q <= 1'b0;
			acc_s_q      <= '0;
			acc_e_q      <= '0;
		end else begin
			i_q <= i_d;
			if (flush_en) begin
				j_q <= new_j;
				if (j_q == '0) begin
					first_full_q <= first_now;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					pend_q       <= 1'b1;
					acc_v_q      <= 1'b0;
					contained_q  <= 1'b0;
					first_full_q <= 1'b0;
					j_q          <= '0;
					state_q      <= bad ? ST_RESULT : ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_FLUSH;
					end else begin
						if (take_chunk) begin
							pend_q <= 1'b0;
						end else if (rd_a <= s_q && e_q <= rd_b) begin
							contained_q <= 1'b1;
						end
						if (merge) begin
							if (item_e > acc_e_q) begin
								acc_e_q <= item_e;
							end
						end else begin
							acc_s_q <= item_s;
							acc_e_q <= item_e;
							acc_v_q <= 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					// a rejected chunk leaves the live bank untouched
					if (!over) begin
						sel_q   <= ~sel_q;
						count_q <= complete ? '0 : new_j;
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (ctrl.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctrl.clear) begin
				count_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ctrl.start) begin
			s_q <= POS_W'(chunk_start);
			e_q <= chunk_end;
		end
		if (state_q == ST_CHECK) begin
			res_q.status         <= STAT_BAD_RANGE;
			res_q.copy_needed    <= 1'b0;
			res_q.interval_count <= COUNT_OUT_W'(count_q);
		end
		if (state_q == ST_FLUSH) begin
			if (over) begin
				res_q.status         <= STAT_TABLE_FULL;
				res_q.copy_needed    <= 1'b0;
				res_q.interval_count <= COUNT_OUT_W'(count_q);
			end else begin
				res_q.status         <= complete ? STAT_COMPLETE : STAT_PARTIAL;
				res_q.copy_needed    <= !contained_q;
				res_q.interval_count <= complete ? '0 : COUNT_OUT_W'(new_j);
			end
		end
	end

	assign ready  = state_q == ST_IDLE;
	assign done   = (state_q == ST_RESULT) && ctrl.out_free;
	assign result = res_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("interval count above table depth");
	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> i_q <= count_q)
		else $error("scan index ran past live entries");
	a_start_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && ctrl.start) |=> state_q == ST_CHECK)
		else $error("start did not enter range check");
	a_full_no_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_TABLE_FULL) |-> !result.copy_needed)
		else $error("table full result asks for copy");
	a_complete_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_COMPLETE) |-> count_q == '0)
		else $error("complete object left intervals");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/chunk_coverage_reassembly_tracker.sv =====
// Top level of the chunk coverage tracker: register port, handshakes, result register.
//
//  channel  dir  handshake              payload
//  apb      in   psel/penable/pready    paddr, pwdata, prdata (object_size)
//  in       in   in_valid/in_stall      chunk_start, chunk_end
//  out      out  out_valid/out_stall    status, copy_needed, interval_count
//
// A chunk's result waits for the merge walk, which reads one stored interval a cycle from
// the live table bank, besides one step that takes in the new chunk.
// A bad range skips the merge walk and goes from the range check to the result step.
// One chunk at a time: in_stall is high from accept until the result is loaded.
// The result register frees the engine; a stalled result holds the engine in its result step.
// Reset clears the interval count and object size; the table needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module chunk_coverage_reassembly_tracker
	import crt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [REG_ADDR_W-1:0]  paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SIZE_BITS-1:0]   chunk_start,
	input  logic [POS_W-1:0]       chunk_end,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic                   copy_needed,
	output logic [COUNT_OUT_W-1:0] interval_count
);

	logic [POS_W-1:0] object_size_q;
	logic             reg_hit, cfg_wr, eng_ready, eng_done;
	logic [POS_W-1:0] wr_val;
	crt_ctrl_t        ctrl;
	crt_result_t      eng_res;
	crt_result_t      out_q;
	logic             out_valid_q;

	assign pready  = 1'b1;
	assign reg_hit = paddr[2] == REG_OBJECT_SIZE;
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign wr_val  = pwdata[POS_W-1:0];
	assign prdata  = reg_hit ? 32'(object_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_size_q <= '0;
		end else if (cfg_wr) begin
			object_size_q <= (wr_val > SIZE_CAP) ? SIZE_CAP : wr_val;
		end
	end

	assign in_stall      = !eng_ready;
	assign ctrl.start    = in_valid && eng_ready;
	assign ctrl.clear    = cfg_wr;
	assign ctrl.out_free = !out_valid_q || !out_stall;

	crt_merge_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.chunk_start (chunk_start),
		.chunk_end   (chunk_end),
		.object_size (object_size_q),
		.ready       (eng_ready),
		.done        (eng_done),
		.result      (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			out_q <= eng_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign copy_needed    = out_q.copy_needed;
	assign interval_count = out_q.interval_count;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the chunk coverage reassembly tracker.
`timescale 1ns / 1ps
module tb;
	import crt_pkg::*;

	localparam int RANDOM_ITEMS = 1550;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 30;

	typedef enum logic {ROW_SIZE, ROW_CHUNK} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [31:0]      size_value;
		logic [15:0]      s;
		logic [16:0]      e;
		bit               typed;
		crt_result_t      known;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [REG_ADDR_W-1:0]  paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [SIZE_BITS-1:0]   chunk_start = '0;
	logic [POS_W-1:0]       chunk_end = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             status;
	logic                   copy_needed;
	logic [COUNT_OUT_W-1:0] interval_count;

	chunk_coverage_reassembly_tracker DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.chunk_start(chunk_start), .chunk_end(chunk_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .copy_needed(copy_needed), .interval_count(interval_count)
	);

	// coverage model: sorted disjoint intervals
	logic [POS_W-1:0] cov_lo [MAX_INTERVALS];
	logic [POS_W-1:0] cov_hi [MAX_INTERVALS];
	int               cov_held = 0;
	logic [POS_W-1:0] obj_size = '0;

	crt_result_t      pending_results[$];
	stim_row_t        stim_rows[$];
	int               fail_count = 0;
	int               cycle_count = 0;
	bit               quiet = 1'b0;
	int               stall_hold = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void absorb_following(input int idx);
		int j;
		while (idx + 1 < cov_held && cov_hi[idx] >= cov_lo[idx + 1]) begin
			if (cov_hi[idx + 1] > cov_hi[idx])
				cov_hi[idx] = cov_hi[idx + 1];
			for (j = idx + 1; j < cov_held - 1; j++) begin
				cov_lo[j] = cov_lo[j + 1];
				cov_hi[j] = cov_hi[j + 1];
			end
			cov_held--;
		end
	endfunction

	function automatic crt_result_t track_chunk(input logic [15:0] s, input logic [16:0] e);
		crt_result_t r;
		int          pos;
		int          i;
		bit          hit;
		r.status = STAT_PARTIAL;
		r.copy_needed = 1'b0;
		hit = 1'b0;
		if ({1'b0, s} >= e || e > obj_size) begin
			r.status = STAT_BAD_RANGE;
		end else begin
			pos = cov_held;
			for (i = 0; i < cov_held; i++) begin
				if (cov_lo[i] <= s && s <= cov_hi[i]) begin
					hit = 1'b1;
					pos = i;
					break;
				end
				if (s < cov_lo[i]) begin
					pos = i;
					break;
				end
			end
			if (hit) begin
				// starts inside or at the end of an interval: only a longer end adds bytes
				if (e > cov_hi[pos]) begin
					cov_hi[pos] = e;
					absorb_following(pos);
					r.copy_needed = 1'b1;
				end
			end else if (pos < cov_held && cov_lo[pos] <= e) begin
				cov_lo[pos] = s;
				if (e > cov_hi[pos])
					cov_hi[pos] = e;
				absorb_following(pos);
				r.copy_needed = 1'b1;
			end else if (cov_held >= MAX_INTERVALS) begin
				r.status = STAT_TABLE_FULL;
			end else begin
				for (i = cov_held; i > pos; i--) begin
					cov_lo[i] = cov_lo[i - 1];
					cov_hi[i] = cov_hi[i - 1];
				end
				cov_lo[pos] = s;
				cov_hi[pos] = e;
				cov_held++;
				r.copy_needed = 1'b1;
			end
			if (r.status == STAT_PARTIAL && cov_held == 1 && cov_lo[0] == 0 &&
			    cov_hi[0] == obj_size) begin
				r.status = STAT_COMPLETE;
				cov_held = 0;
			end
		end
		r.interval_count = cov_held[COUNT_OUT_W-1:0];
		return r;
	endfunction

	// result side: check every beat, stall for a drawn number of valid cycles
	always @(posedge clk) begin
		crt_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: status %0d copy %0d count %0d",
					       status, copy_needed, interval_count);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (copy_needed !== want.copy_needed) begin
						$error("copy_needed: expected %0d, got %0d", want.copy_needed,
						       copy_needed);
						fail_count++;
					end
					if (interval_count !== want.interval_count) begin
						$error("interval_count: expected %0d, got %0d",
						       want.interval_count, interval_count);
						fail_count++;
					end
				end
				stall_hold = quiet ? 0 : $urandom_range(0, 4);
			end else if (out_valid && stall_hold > 0) begin
				stall_hold--;
			end
			out_stall <= (stall_hold > 0);
		end
	end

	task automatic set_object_size(input logic [31:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_OBJECT_SIZE, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		obj_size = (value[16:0] > SIZE_CAP) ? SIZE_CAP : value[16:0];
		cov_held = 0;
	endtask

	task automatic send_chunk(input logic [15:0] s, input logic [16:0] e, input bit typed,
	                          input crt_result_t known);
		int          gap;
		crt_result_t predicted;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		chunk_start <= s;
		chunk_end <= e;
		do
			@(posedge clk);
		while (in_stall);
		predicted = track_chunk(s, e);
		pending_results.insert(pending_results.size(), typed ? known : predicted);
	endtask

	function automatic void add_size(input logic [31:0] value);
		stim_row_t row;
		row.kind = ROW_SIZE;
		row.size_value = value;
		row.s = '0;
		row.e = '0;
		row.typed = 1'b0;
		row.known = '0;
		stim_rows.insert(stim_rows.size(), row);
	endfunction

	function automatic void add_chunk(input logic [15:0] s, input logic [16:0] e,
	                                  input bit typed, input status_t st, input logic cp,
	                                  input logic [COUNT_OUT_W-1:0] cnt);
		stim_row_t row;
		row.kind = ROW_CHUNK;
		row.size_value = '0;
		row.s = s;
		row.e = e;
		row.typed = typed;
		row.known.status = st;
		row.known.copy_needed = cp;
		row.known.interval_count = cnt;
		stim_rows.insert(stim_rows.size(), row);
	endfunction

	initial begin
		int          k;
		int          sent;
		int          pick;
		int          size_draw;
		int          eff;
		int          span;
		int          phase_len;
		int          s_draw;
		int          e_top;
		logic [15:0] s;
		logic [16:0] e;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// size zero rejects everything
		add_size(0);
		add_chunk(0, 1, 1, STAT_BAD_RANGE, 0, 0);
		add_chunk(16'hFFFF, 17'h10000, 1, STAT_BAD_RANGE, 0, 0);
		// oversized write saturates to the full range
		add_size(32'h1FFFF);
		add_chunk(5, 5, 1, STAT_BAD_RANGE, 0, 0);
		add_chunk(0, 17'h1FFFF, 1, STAT_BAD_RANGE, 0, 0);
		add_chunk(16'hFFFF, 17'h10000, 1, STAT_PARTIAL, 1, 1);
		add_chunk(0, 17'h0FFFF, 1, STAT_COMPLETE, 1, 0);
		// merges on a small object
		add_size(64);
		add_chunk(0, 64, 1, STAT_COMPLETE, 1, 0);
		add_chunk(10, 20, 1, STAT_PARTIAL, 1, 1);
		add_chunk(12, 18, 0, STAT_PARTIAL, 0, 0);
		add_chunk(20, 30, 0, STAT_PARTIAL, 0, 0);
		add_chunk(5, 10, 0, STAT_PARTIAL, 0, 0);
		add_chunk(40, 50, 0, STAT_PARTIAL, 0, 0);
		add_chunk(0, 64, 0, STAT_PARTIAL, 0, 0);
		// fill the table with isolated single bytes, then overflow it
		add_size(64);
		for (k = 0; k < MAX_INTERVALS; k++)
			add_chunk(16'(2 * k), 17'(2 * k + 1), 0, STAT_PARTIAL, 0, 0);
		add_chunk(40, 41, 1, STAT_TABLE_FULL, 0, COUNT_OUT_W'(MAX_INTERVALS));
		add_chunk(1, 2, 0, STAT_PARTIAL, 0, 0);
		add_size(1);
		add_chunk(0, 1, 1, STAT_COMPLETE, 1, 0);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_SIZE)
				set_object_size(stim_rows[i].size_value);
			else
				send_chunk(stim_rows[i].s, stim_rows[i].e, stim_rows[i].typed,
				           stim_rows[i].known);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				size_draw = 0;
			else if (pick <= 2)
				size_draw = $urandom_range(1, 8);
			else if (pick == 3)
				size_draw = 65536;
			else if (pick == 4)
				size_draw = $urandom_range(65537, 131071);
			else if (pick == 5)
				size_draw = $urandom_range(9, 65535);
			else
				size_draw = $urandom_range(16, 96);
			set_object_size(size_draw);
			eff = int'(obj_size);
			span = $urandom_range(1, eff / 4 + 1);
			quiet = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 60);
			repeat (phase_len) begin
				if (eff == 0 || $urandom_range(0, 9) == 0) begin
					// noise: raw fields, sometimes an empty chunk
					s = 16'($urandom);
					e = 17'($urandom);
					if ($urandom_range(0, 1) == 0)
						e = {1'b0, s};
				end else begin
					s_draw = $urandom_range(0, eff - 1);
					e_top = (s_draw + span > eff) ? eff : s_draw + span;
					s = 16'(s_draw);
					e = 17'($urandom_range(s_draw + 1, e_top));
					if (eff > 4096 && $urandom_range(0, 7) == 0)
						e = 17'(eff);
				end
				send_chunk(s, e, 0, '0);
				sent++;
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/crt_pkg.sv
rtl/core/crt_merge_engine.sv
rtl/core/chunk_coverage_reassembly_tracker.sv
tb/tb.sv
